// ===== rtl/slfe_pkg.sv =====
// ----------------------------------------------------------------------------
// slfe_pkg: shared types and constants for the sync/length deframer
// Queue entry tag, register codes and reset values.
// ----------------------------------------------------------------------------
package slfe_pkg;

	localparam logic [7:0] SYNC_RESET = 8'hAA;
	localparam logic [7:0] MAXP_RESET = 8'd70;

	localparam logic REG_SYNC = 1'b0;
	localparam logic REG_MAXP = 1'b1;

	typedef struct packed {
		logic hdr;   // entry is a header burst
		logic last;  // frame ends with this entry
	} slfe_tag_t;

endpackage

// ===== rtl/sync_length_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_extractor: sync-byte, length-prefixed deframer
// Throughput: one rx byte per cycle; rx_stall rises only when the queue of
//   HEADER_LEN + 1 entries is full, i.e. when the output side stalls.
// Path: with an empty queue, an rx transfer writes an entry into the queue and
//   the output register takes the frame transfer from it; a header burst goes
//   out one byte a cycle unless stalled, and payload bytes queue behind it.
// Reset: async, active low; hunting, queue empty, registers to 0xAA and 70.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor #(
	parameter int HEADER_LEN = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [7:0]  frame_byte,
	output logic        is_first,
	output logic        is_last
);

	localparam int TW     = $bits(slfe_pkg::slfe_tag_t);
	localparam int W      = HEADER_LEN * 8 + TW;
	localparam int QDEPTH = HEADER_LEN + 1;

	logic [7:0]                 sync_q;
	logic [7:0]                 maxp_q;
	logic                       take;
	logic                       push;
	slfe_pkg::slfe_tag_t        push_tag;
	logic [HEADER_LEN-1:0][7:0] push_data;
	logic                       pop;
	logic [W-1:0]               rdata;
	logic                       full;
	logic                       empty;
	slfe_pkg::slfe_tag_t        q_tag;
	logic [HEADER_LEN-1:0][7:0] q_data;

	assign pready = 1'b1;
	assign prdata = {24'd0, (paddr[2] == slfe_pkg::REG_MAXP) ? maxp_q : sync_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= slfe_pkg::SYNC_RESET;
			maxp_q <= slfe_pkg::MAXP_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				slfe_pkg::REG_SYNC: sync_q <= pwdata[7:0];
				slfe_pkg::REG_MAXP: maxp_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign rx_stall = full;
	assign take     = rx_valid && !rx_stall;

	slfe_front #(.HEADER_LEN(HEADER_LEN)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (rx_byte),
		.sync_value  (sync_q),
		.max_payload (maxp_q),
		.push        (push),
		.push_tag    (push_tag),
		.push_data   (push_data)
	);

	slfe_fifo #(.W(W), .DEPTH(QDEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_tag, push_data}),
		.pop    (pop),
		.rdata  (rdata),
		.full   (full),
		.empty  (empty)
	);

	assign q_tag  = rdata[W-1 -: TW];
	assign q_data = rdata[HEADER_LEN*8-1:0];

	slfe_back #(.HEADER_LEN(HEADER_LEN)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.tag         (q_tag),
		.data        (q_data),
		.pop         (pop),
		.frame_stall (frame_stall),
		.frame_valid (frame_valid),
		.frame_byte  (frame_byte),
		.is_first    (is_first),
		.is_last     (is_last)
	);

endmodule

// ===== rtl/slfe_front.sv =====
// ----------------------------------------------------------------------------
// slfe_front: byte classifier
// Hunts for sync, gathers the header, checks the length and pushes header
// bursts and payload bytes into the queue.
// ----------------------------------------------------------------------------
module slfe_front #(
	parameter int HEADER_LEN = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [7:0]                  rx_byte,
	input  logic [7:0]                  sync_value,
	input  logic [7:0]                  max_payload,
	output logic                        push,
	output slfe_pkg::slfe_tag_t         push_tag,
	output logic [HEADER_LEN-1:0][7:0]  push_data
);

	localparam int CW = $clog2(HEADER_LEN);

	typedef enum logic [1:0] {
		HUNT,
		HEADER,
		PAYLOAD
	} phase_t;

	phase_t                     phase_q;
	logic [CW-1:0]              cnt_q;
	logic [7:0]                 left_q;
	logic [HEADER_LEN-1:0][7:0] sh_q;
	logic [HEADER_LEN-1:0][7:0] sh_next;
	logic                       hdr_done;

	assign sh_next  = {rx_byte, sh_q[HEADER_LEN-1:1]};
	assign hdr_done = (cnt_q == CW'(HEADER_LEN - 1));

	always_comb begin
		push      = 1'b0;
		push_tag  = '0;
		push_data = sh_next;
		unique case (phase_q)
			HEADER: begin
				if (take && hdr_done && rx_byte <= max_payload) begin
					push          = 1'b1;
					push_tag.hdr  = 1'b1;
					push_tag.last = (rx_byte == 8'd0);
				end
			end
			PAYLOAD: begin
				push          = take;
				push_data[0]  = rx_byte;
				push_tag.last = (left_q == 8'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT;
			cnt_q   <= '0;
			left_q  <= '0;
		end else if (take) begin
			unique case (phase_q)
				HEADER: begin
					if (hdr_done) begin
						cnt_q <= '0;
						if (rx_byte > max_payload || rx_byte == 8'd0) begin
							phase_q <= HUNT;
						end else begin
							phase_q <= PAYLOAD;
							left_q  <= rx_byte;
						end
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				PAYLOAD: begin
					left_q <= left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_q <= HUNT;
					end
				end
				default: begin
					if (rx_byte == sync_value) begin
						phase_q <= HEADER;
						cnt_q   <= CW'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sh_q <= sh_next;
		end
	end

endmodule

// ===== rtl/slfe_fifo.sv =====
// ----------------------------------------------------------------------------
// slfe_fifo: entry queue
// Short register queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module slfe_fifo #(
	parameter int W     = 34,
	parameter int DEPTH = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			priority if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/slfe_back.sv =====
// ----------------------------------------------------------------------------
// slfe_back: output sequencer
// Pops queue entries, expands header bursts one byte a cycle while the output
// is not stalled and drives the registered output channel.
// ----------------------------------------------------------------------------
module slfe_back #(
	parameter int HEADER_LEN = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  slfe_pkg::slfe_tag_t         tag,
	input  logic [HEADER_LEN-1:0][7:0]  data,
	output logic                        pop,
	input  logic                        frame_stall,
	output logic                        frame_valid,
	output logic [7:0]                  frame_byte,
	output logic                        is_first,
	output logic                        is_last
);

	localparam int CW = $clog2(HEADER_LEN);

	logic                       adv;
	logic                       bact_q;
	logic                       blast_q;
	logic [CW-1:0]              bidx_q;
	logic [HEADER_LEN-1:0][7:0] bdata_q;
	logic                       bend;

	assign adv  = !frame_valid || !frame_stall;
	assign pop  = adv && !bact_q && !empty;
	assign bend = (bidx_q == CW'(HEADER_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
			bact_q      <= 1'b0;
			blast_q     <= 1'b0;
			bidx_q      <= '0;
			frame_byte  <= '0;
			is_first    <= 1'b0;
			is_last     <= 1'b0;
		end else if (adv) begin
			priority if (bact_q) begin
				frame_valid <= 1'b1;
				frame_byte  <= bdata_q[bidx_q];
				is_first    <= 1'b0;
				is_last     <= blast_q && bend;
				bidx_q      <= bidx_q + CW'(1);
				if (bend) begin
					bact_q <= 1'b0;
				end
			end else if (!empty) begin
				frame_valid <= 1'b1;
				frame_byte  <= data[0];
				if (tag.hdr) begin
					is_first <= 1'b1;
					is_last  <= 1'b0;
					bact_q   <= 1'b1;
					blast_q  <= tag.last;
					bidx_q   <= CW'(1);
				end else begin
					is_first <= 1'b0;
					is_last  <= tag.last;
				end
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tag.hdr) begin
			bdata_q <= data;
		end
	end

endmodule

// ===== bench/sync_length_frame_extractor_check.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_check: deframer predictor and output checker
// Watches the register port and both channels, predicts the frame bytes from
// each rx transfer and compares every frame transfer with the oldest one due.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor_check #(
	parameter int HDR_LEN = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_valid,
	input  logic        frame_stall,
	input  logic [7:0]  frame_byte,
	input  logic        is_first,
	input  logic        is_last,
	output int          pending,
	output logic        in_frame,
	output int          fail_count
);

	localparam logic [2:0] ADDR_SYNC = {slfe_pkg::REG_SYNC, 2'b00};
	localparam logic [2:0] ADDR_MAXP = {slfe_pkg::REG_MAXP, 2'b00};

	typedef enum logic [1:0] {HUNT, HEADER, PAYLOAD} deframe_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} frame_beat_t;

	frame_beat_t    due_beats[$];
	logic [7:0]     sync_val;
	logic [7:0]     max_len;
	deframe_phase_t phase;
	logic [7:0]     hdr_buf [HDR_LEN];
	int             hdr_cnt;
	logic [7:0]     left;

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		if (fail_count < 40) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
		fail_count++;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0] len;
		case (phase)
			HEADER: begin
				hdr_buf[hdr_cnt] = b;
				hdr_cnt++;
				if (hdr_cnt == HDR_LEN) begin
					len = hdr_buf[HDR_LEN-1];
					hdr_cnt = 0;
					if (len > max_len) begin
						phase = HUNT;
					end else begin
						for (int i = 0; i < HDR_LEN; i++) begin
							due_beats.push_back('{hdr_buf[i], i == 0,
								(i == HDR_LEN - 1) && (len == 8'd0)});
						end
						if (len == 8'd0) begin
							phase = HUNT;
						end else begin
							left = len;
							phase = PAYLOAD;
						end
					end
				end
			end
			PAYLOAD: begin
				left = left - 8'd1;
				due_beats.push_back('{b, 1'b0, left == 8'd0});
				if (left == 8'd0) begin
					phase = HUNT;
				end
			end
			default: begin
				if (b == sync_val) begin
					hdr_buf[0] = b;
					hdr_cnt = 1;
					phase = HEADER;
				end
			end
		endcase
	endtask

	task automatic check_beat();
		frame_beat_t want;
		if (due_beats.size() == 0) begin
			report_mismatch($sformatf("unexpected frame byte %02h", frame_byte));
			return;
		end
		want = due_beats.pop_front();
		if (frame_byte !== want.data) begin
			report_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte, want.data));
		end
		if (is_first !== want.first) begin
			report_mismatch($sformatf("is_first %b, want %b", is_first, want.first));
		end
		if (is_last !== want.last) begin
			report_mismatch($sformatf("is_last %b, want %b", is_last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_val = slfe_pkg::SYNC_RESET;
			max_len = slfe_pkg::MAXP_RESET;
			phase = HUNT;
			hdr_cnt = 0;
			left = 8'd0;
			due_beats.delete();
		end else begin
			if (frame_valid && !frame_stall) begin
				check_beat();
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_SYNC) begin
					sync_val = pwdata[7:0];
				end else if (paddr == ADDR_MAXP) begin
					max_len = pwdata[7:0];
				end
			end
			if (rx_valid && !rx_stall) begin
				deframe_byte(rx_byte);
			end
		end
		pending <= due_beats.size();
		in_frame <= (phase != HUNT);
	end

endmodule

// ===== bench/sync_length_frame_extractor_test.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_extractor_test: stimulus and verdict for the deframer
// Sends directed and random byte streams (frames, noise, cut-off and
// oversized headers) under several register settings with random gaps and
// output stalls, including one long output hold-off; the checker predicts.
// ----------------------------------------------------------------------------
module sync_length_frame_extractor_test;

	localparam int HDR_LEN = 4;
	localparam logic [2:0] ADDR_SYNC = {slfe_pkg::REG_SYNC, 2'b00};
	localparam logic [2:0] ADDR_MAXP = {slfe_pkg::REG_MAXP, 2'b00};

	localparam logic [7:0] OPENING [26] = '{
		8'h00, 8'hFF, 8'h55,
		8'hAA, 8'hAA, 8'hFF, 8'h02, 8'hAA, 8'h00,
		8'hAA, 8'h11, 8'h22, 8'h00,
		8'hAA, 8'h01, 8'h02, 8'd71,
		8'hAA, 8'hAA, 8'hAA, 8'hFF,
		8'hAA, 8'h80, 8'h7F, 8'h01, 8'hFF
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte = '0;
	logic        frame_valid;
	logic        frame_stall = 1'b0;
	logic [7:0]  frame_byte;
	logic        is_first;
	logic        is_last;

	int          pending;
	logic        in_frame;
	int          fail_count;

	logic [7:0]  sync_cur = slfe_pkg::SYNC_RESET;
	logic [7:0]  max_cur = slfe_pkg::MAXP_RESET;
	int          frame_bytes;
	bit          dense = 1'b0;
	bit          hold_req = 1'b0;

	sync_length_frame_extractor #(.HEADER_LEN(HDR_LEN)) uut (.*);

	sync_length_frame_extractor_check #(.HDR_LEN(HDR_LEN)) check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (dense || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] pick_len();
		int r;
		int m;
		m = int'(max_cur);
		r = $urandom_range(0, 99);
		if (r < 55) return 8'($urandom_range(0, m < 8 ? m : 8));
		if (r < 80) return 8'($urandom_range(0, m < 30 ? m : 30));
		if (r < 90 && m <= 70) return 8'(m);
		if (m < 255) return 8'($urandom_range(m + 1, 255));
		return 8'($urandom_range(0, 8));
	endfunction

	function automatic logic [7:0] body_byte();
		return ($urandom_range(0, 7) == 0) ? sync_cur : 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
	endtask

	task automatic send_frame(input logic [7:0] len);
		send_byte(sync_cur);
		for (int i = 1; i < HDR_LEN - 1; i++) begin
			send_byte(body_byte());
		end
		send_byte(len);
		frame_bytes += HDR_LEN;
		if (len <= max_cur) begin
			for (int i = 0; i < len; i++) begin
				send_byte(body_byte());
			end
			frame_bytes += len;
		end
	endtask

	// feed filler until the deframer is back to hunting
	task automatic settle();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (in_frame) begin
			send_byte(~sync_cur);
			rx_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [7:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'd0, data};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reconfig(input logic [7:0] s, input logic [7:0] m);
		drain();
		apb_write(ADDR_SYNC, s);
		apb_write(ADDR_MAXP, m);
		sync_cur = s;
		max_cur = m;
	endtask

	task automatic run_random(input int budget);
		int r;
		int k;
		frame_bytes = 0;
		while (frame_bytes < budget) begin
			if (frame_bytes > budget / 2) dense = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_frame(pick_len());
			end else if (r < 90) begin
				k = $urandom_range(1, 4);
				repeat (k) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// cut-off header: the next bytes complete it
				k = $urandom_range(1, HDR_LEN - 2);
				send_byte(sync_cur);
				repeat (k) send_byte(body_byte());
				frame_bytes += k + 1;
			end
		end
		settle();
	endtask

	initial begin
		int n;
		bit held;
		held = 1'b0;
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				frame_stall <= 1'b1;
				repeat (150) @(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				frame_stall <= 1'b1;
				n = gap_len() + 1;
				repeat (n) @(posedge clk);
			end else begin
				frame_stall <= 1'b0;
				n = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING[i]) send_byte(OPENING[i]);
		settle();

		reconfig(8'h00, 8'h00);
		run_random(60);

		reconfig(8'hFF, 8'hFF);
		run_random(70);

		reconfig(slfe_pkg::SYNC_RESET, slfe_pkg::MAXP_RESET);
		dense = 1'b1;
		hold_req = 1'b1;
		run_random(90);

		reconfig(8'($urandom_range(0, 255)), 8'($urandom_range(1, 30)));
		run_random(70);

		drain();
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
